// ===== sv/tcrd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and defaults of the tempo-change region detector.
package tcrd_pkg;

    // Default sizes handed to the top level
    localparam int TCRD_MAX_REGIONS = 64;
    localparam int TCRD_TIME_BITS   = 32;

    // Q0.16 tolerance and field widths
    localparam int FRAC_BITS  = 16;
    localparam int TOL_BITS   = 16;
    localparam int LIMIT_BITS = 32;
    localparam int OUT_TIME_BITS  = 32;
    localparam int OUT_COUNT_BITS = 7;

    // Beat counter: detection starts once six beats are in the history
    localparam int SEEN_W = 3;
    localparam logic [SEEN_W-1:0] SEEN_DETECT = 3'd6;
    localparam logic [SEEN_W-1:0] SEEN_MAX    = 3'd7;

    // Ratio test sequencer: six tests, the first four of kind "at least"
    localparam int TEST_W = 3;
    localparam logic [TEST_W-1:0] TEST_LAST     = 3'd5;
    localparam logic [TEST_W-1:0] TEST_FIRST_LE = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_REGION_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_REGION_MIN = 2'd2;

    // Configuration reset values
    localparam logic [TOL_BITS-1:0]   TOLERANCE_RESET        = 16'd5243;
    localparam logic [LIMIT_BITS-1:0] LONG_REGION_MAX_RESET  = 32'd20000;
    localparam logic [LIMIT_BITS-1:0] SHORT_REGION_MIN_RESET = 32'd4000;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_DET,
        ST_UPD,
        ST_FIN,
        ST_ERD,
        ST_EOUT
    } state_t;

endpackage

// ===== sv/tempo_change_region_detector.sv =====
`timescale 1ns / 1ps
// Tempo-change region detector: one shared multiplier under a small sequencer.
//
//  channel   direction  handshake                  payload
//  beat      in         beat_valid / beat_stall    beat_time, beat_last
//  result    out        result_valid / result_stall region_start .. result_last
//  cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A beat before the seventh of a list only updates the history; from the
// seventh on each beat also runs six ratio tests through the one multiplier,
// each a multiply step and a compare step. The last beat adds a finish step,
// then a stack read and an output step per region (or for the empty list).
// Reset clears all control state; the stacks are not cleared.
// result_stall holds the output register; a new list waits only for its own
// results to find that register free.
module tempo_change_region_detector #(
    parameter int MAX_REGIONS = tcrd_pkg::TCRD_MAX_REGIONS,
    parameter int TIME_BITS   = tcrd_pkg::TCRD_TIME_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   beat_valid,
    output logic                                   beat_stall,
    input  logic [TIME_BITS-1:0]                   beat_time,
    input  logic                                   beat_last,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic [tcrd_pkg::OUT_TIME_BITS-1:0]     region_start,
    output logic [tcrd_pkg::OUT_TIME_BITS-1:0]     region_stop,
    output logic                                   region_valid,
    output logic [tcrd_pkg::OUT_COUNT_BITS-1:0]    region_count,
    output logic                                   order_error,
    output logic                                   overflow,
    output logic                                   result_last,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tcrd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tcrd_pkg::LIMIT_BITS-1:0]        cfg_data
);

    localparam int DEPTH_W = $clog2(MAX_REGIONS + 1);
    localparam int IDX_W   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CMP_W   = (TIME_BITS > tcrd_pkg::LIMIT_BITS) ? TIME_BITS
                                                                : tcrd_pkg::LIMIT_BITS;
    localparam int PROD_W  = TIME_BITS + tcrd_pkg::FRAC_BITS;
    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(MAX_REGIONS);

    // Sequencer
    tcrd_pkg::state_t state_reg, state_next;

    // Configuration
    logic [tcrd_pkg::TOL_BITS-1:0]   tol_reg;
    logic [tcrd_pkg::LIMIT_BITS-1:0] long_reg;
    logic [tcrd_pkg::LIMIT_BITS-1:0] short_reg;

    // Beat history and detector state
    logic [TIME_BITS-1:0] beat_reg, beat_next;
    logic                 last_reg, last_next;
    logic [TIME_BITS-1:0] b0_reg, b0_next, b1_reg, b1_next;
    logic [TIME_BITS-1:0] d0_reg, d0_next, d1_reg, d1_next, d2_reg, d2_next;
    logic [TIME_BITS-1:0] d3_reg, d3_next, d4_reg, d4_next;
    logic [tcrd_pkg::SEEN_W-1:0] seen_reg, seen_next;
    logic                 in_region_reg, in_region_next;
    logic [DEPTH_W-1:0]   start_depth_reg, start_depth_next;
    logic [DEPTH_W-1:0]   stop_depth_reg, stop_depth_next;
    logic                 err_reg, err_next;
    logic                 ovf_reg, ovf_next;

    // Ratio test unit
    logic                 step_reg, step_next;
    logic [tcrd_pkg::TEST_W-1:0] tst_reg, tst_next;
    logic [PROD_W-1:0]    lhs_reg, lhs_next, prod_reg, prod_next;
    logic [TIME_BITS-1:0] dx, dy, diff;
    logic                 test_pass;

    // Emission
    logic [DEPTH_W-1:0]   k_reg, k_next;

    // Output register
    logic                 res_valid_reg, res_valid_next;
    logic [tcrd_pkg::OUT_TIME_BITS-1:0]  res_start_reg, res_start_next;
    logic [tcrd_pkg::OUT_TIME_BITS-1:0]  res_stop_reg, res_stop_next;
    logic                 res_rvalid_reg, res_rvalid_next;
    logic [tcrd_pkg::OUT_COUNT_BITS-1:0] res_count_reg, res_count_next;
    logic                 res_err_reg, res_err_next;
    logic                 res_ovf_reg, res_ovf_next;
    logic                 res_last_reg, res_last_next;

    // Region stacks
    logic [TIME_BITS-1:0] start_mem [MAX_REGIONS];
    logic [TIME_BITS-1:0] stop_mem  [MAX_REGIONS];
    logic [TIME_BITS-1:0] rd_start_reg, rd_stop_reg;
    logic [IDX_W-1:0]     start_raddr, stop_raddr, start_waddr, stop_waddr;
    logic [TIME_BITS-1:0] start_wdata, stop_wdata;
    logic                 start_we, stop_we;

    // Gaps against stack tops
    logic [DEPTH_W-1:0]   start_dm1, stop_dm1;
    logic [TIME_BITS-1:0] stop_gap, long_gap, fin_gap, new_interval;
    logic                 near_stop, too_long, fin_long, out_free, last_result;

    assign beat_stall   = (state_reg != tcrd_pkg::ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign region_start = res_start_reg;
    assign region_stop  = res_stop_reg;
    assign region_valid = res_rvalid_reg;
    assign region_count = res_count_reg;
    assign order_error  = res_err_reg;
    assign overflow     = res_ovf_reg;
    assign result_last  = res_last_reg;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= tcrd_pkg::TOLERANCE_RESET;
            long_reg  <= tcrd_pkg::LONG_REGION_MAX_RESET;
            short_reg <= tcrd_pkg::SHORT_REGION_MIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tcrd_pkg::CFG_TOLERANCE:
                    tol_reg <= cfg_data[tcrd_pkg::TOL_BITS-1:0];
                tcrd_pkg::CFG_LONG_REGION_MAX:
                    long_reg <= cfg_data;
                tcrd_pkg::CFG_SHORT_REGION_MIN:
                    short_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // Stack tops and gaps, all modulo the time width
    assign start_dm1    = start_depth_reg - 1'b1;
    assign stop_dm1     = stop_depth_reg - 1'b1;
    assign stop_gap     = b1_reg - rd_stop_reg;
    assign long_gap     = b1_reg - rd_start_reg;
    assign fin_gap      = beat_reg - rd_start_reg;
    assign new_interval = beat_reg - b0_reg;
    assign near_stop    = CMP_W'(stop_gap) < CMP_W'(short_reg);
    assign too_long     = CMP_W'(long_gap) > CMP_W'(long_reg);
    assign fin_long     = CMP_W'(fin_gap) > CMP_W'(long_reg);
    assign out_free     = !res_valid_reg || !result_stall;
    assign last_result  = (k_reg == stop_dm1);

    // Select the interval pair of the current ratio test
    always_comb
    begin
        case (tst_reg)
            3'd0:    begin dx = d0_reg; dy = d3_reg; end
            3'd1:    begin dx = d1_reg; dy = d4_reg; end
            3'd2:    begin dx = d1_reg; dy = d3_reg; end
            3'd3:    begin dx = d0_reg; dy = d4_reg; end
            3'd4:    begin dx = d0_reg; dy = d1_reg; end
            3'd5:    begin dx = d3_reg; dy = d4_reg; end
            default: begin dx = d0_reg; dy = d1_reg; end
        endcase
        diff = (dx > dy) ? (dx - dy) : (dy - dx);
        if (tst_reg < tcrd_pkg::TEST_FIRST_LE)
            test_pass = (lhs_reg >= prod_reg);
        else
            test_pass = (lhs_reg <= prod_reg);
    end

    // Next state, datapath and stack writes
    always_comb
    begin
        state_next       = state_reg;
        beat_next        = beat_reg;
        last_next        = last_reg;
        b0_next          = b0_reg;
        b1_next          = b1_reg;
        d0_next          = d0_reg;
        d1_next          = d1_reg;
        d2_next          = d2_reg;
        d3_next          = d3_reg;
        d4_next          = d4_reg;
        seen_next        = seen_reg;
        in_region_next   = in_region_reg;
        start_depth_next = start_depth_reg;
        stop_depth_next  = stop_depth_reg;
        err_next         = err_reg;
        ovf_next         = ovf_reg;
        step_next        = step_reg;
        tst_next         = tst_reg;
        lhs_next         = lhs_reg;
        prod_next        = prod_reg;
        k_next           = k_reg;
        res_valid_next   = res_valid_reg;
        res_start_next   = res_start_reg;
        res_stop_next    = res_stop_reg;
        res_rvalid_next  = res_rvalid_reg;
        res_count_next   = res_count_reg;
        res_err_next     = res_err_reg;
        res_ovf_next     = res_ovf_reg;
        res_last_next    = res_last_reg;
        start_raddr      = start_dm1[IDX_W-1:0];
        stop_raddr       = stop_dm1[IDX_W-1:0];
        start_we         = 1'b0;
        stop_we          = 1'b0;
        start_waddr      = start_depth_reg[IDX_W-1:0];
        stop_waddr       = stop_depth_reg[IDX_W-1:0];
        start_wdata      = b1_reg;
        stop_wdata       = b1_reg;

        // Drop a delivered result from the output register
        if (res_valid_reg && !result_stall)
            res_valid_next = 1'b0;

        case (state_reg)
            tcrd_pkg::ST_IDLE:
            begin
                if (beat_valid)
                begin
                    beat_next = beat_time;
                    last_next = beat_last;
                    step_next = 1'b1;
                    tst_next  = '0;
                    if (seen_reg >= tcrd_pkg::SEEN_DETECT)
                        state_next = tcrd_pkg::ST_MUL;
                    else
                        state_next = tcrd_pkg::ST_UPD;
                end
            end

            tcrd_pkg::ST_MUL:
            begin
                lhs_next   = {diff, {tcrd_pkg::FRAC_BITS{1'b0}}};
                prod_next  = PROD_W'(tol_reg) * PROD_W'(dx);
                state_next = tcrd_pkg::ST_CMP;
            end

            tcrd_pkg::ST_CMP:
            begin
                step_next = step_reg & test_pass;
                if (tst_reg == tcrd_pkg::TEST_LAST)
                    state_next = tcrd_pkg::ST_DET;
                else
                begin
                    tst_next   = tst_reg + 1'b1;
                    state_next = tcrd_pkg::ST_MUL;
                end
            end

            tcrd_pkg::ST_DET:
            begin
                // Open, merge, move or close a region at the event time
                if (step_reg)
                begin
                    if (!in_region_reg)
                    begin
                        in_region_next = 1'b1;
                        if (stop_depth_reg != '0 && near_stop)
                            stop_depth_next = stop_dm1;
                        else if (start_depth_reg == DEPTH_FULL)
                            ovf_next = 1'b1;
                        else
                        begin
                            start_we         = 1'b1;
                            start_depth_next = start_depth_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (start_depth_reg != '0 && too_long)
                        begin
                            start_we    = 1'b1;
                            start_waddr = start_dm1[IDX_W-1:0];
                        end
                        else if (stop_depth_reg != '0 && near_stop)
                            stop_depth_next = stop_dm1;
                        else
                        begin
                            in_region_next = 1'b0;
                            if (stop_depth_reg == DEPTH_FULL)
                                ovf_next = 1'b1;
                            else
                            begin
                                stop_we         = 1'b1;
                                stop_depth_next = stop_depth_reg + 1'b1;
                            end
                        end
                    end
                end
                state_next = tcrd_pkg::ST_UPD;
            end

            tcrd_pkg::ST_UPD:
            begin
                // Check order and advance the beat and interval history
                if (seen_reg != '0)
                begin
                    if (beat_reg <= b0_reg)
                        err_next = 1'b1;
                    d0_next = new_interval;
                    d1_next = d0_reg;
                    d2_next = d1_reg;
                    d3_next = d2_reg;
                    d4_next = d3_reg;
                end
                b1_next = b0_reg;
                b0_next = beat_reg;
                if (seen_reg != tcrd_pkg::SEEN_MAX)
                    seen_next = seen_reg + 1'b1;
                if (last_reg)
                    state_next = tcrd_pkg::ST_FIN;
                else
                    state_next = tcrd_pkg::ST_IDLE;
            end

            tcrd_pkg::ST_FIN:
            begin
                // Close or prune an open region with the last beat
                if (in_region_reg)
                begin
                    in_region_next = 1'b0;
                    if (start_depth_reg != '0 && fin_long)
                        start_depth_next = start_dm1;
                    else if (stop_depth_reg == DEPTH_FULL)
                        ovf_next = 1'b1;
                    else
                    begin
                        stop_we         = 1'b1;
                        stop_wdata      = beat_reg;
                        stop_depth_next = stop_depth_reg + 1'b1;
                    end
                end
                k_next     = '0;
                state_next = tcrd_pkg::ST_ERD;
            end

            tcrd_pkg::ST_ERD:
            begin
                start_raddr = k_reg[IDX_W-1:0];
                stop_raddr  = k_reg[IDX_W-1:0];
                state_next  = tcrd_pkg::ST_EOUT;
            end

            tcrd_pkg::ST_EOUT:
            begin
                // Hold the read address so a stalled pair stays in the read registers
                start_raddr = k_reg[IDX_W-1:0];
                stop_raddr  = k_reg[IDX_W-1:0];
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_count_next = tcrd_pkg::OUT_COUNT_BITS'(stop_depth_reg);
                    res_err_next   = err_reg && (seen_reg == tcrd_pkg::SEEN_MAX);
                    res_ovf_next   = ovf_reg;
                    if (stop_depth_reg == '0)
                    begin
                        res_start_next  = '0;
                        res_stop_next   = '0;
                        res_rvalid_next = 1'b0;
                        res_last_next   = 1'b1;
                    end
                    else
                    begin
                        res_start_next  = tcrd_pkg::OUT_TIME_BITS'(rd_start_reg);
                        res_stop_next   = tcrd_pkg::OUT_TIME_BITS'(rd_stop_reg);
                        res_rvalid_next = 1'b1;
                        res_last_next   = last_result;
                    end
                    if (stop_depth_reg == '0 || last_result)
                    begin
                        // List done: return to reset for the next one
                        b0_next          = '0;
                        b1_next          = '0;
                        d0_next          = '0;
                        d1_next          = '0;
                        d2_next          = '0;
                        d3_next          = '0;
                        d4_next          = '0;
                        seen_next        = '0;
                        in_region_next   = 1'b0;
                        start_depth_next = '0;
                        stop_depth_next  = '0;
                        err_next         = 1'b0;
                        ovf_next         = 1'b0;
                        state_next       = tcrd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = tcrd_pkg::ST_ERD;
                    end
                end
            end

            default:
                state_next = tcrd_pkg::ST_IDLE;
        endcase
    end

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tcrd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold control state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg          <= '0;
            b1_reg          <= '0;
            d0_reg          <= '0;
            d1_reg          <= '0;
            d2_reg          <= '0;
            d3_reg          <= '0;
            d4_reg          <= '0;
            seen_reg        <= '0;
            in_region_reg   <= 1'b0;
            start_depth_reg <= '0;
            stop_depth_reg  <= '0;
            err_reg         <= 1'b0;
            ovf_reg         <= 1'b0;
            last_reg        <= 1'b0;
            step_reg        <= 1'b0;
            tst_reg         <= '0;
            k_reg           <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            b0_reg          <= b0_next;
            b1_reg          <= b1_next;
            d0_reg          <= d0_next;
            d1_reg          <= d1_next;
            d2_reg          <= d2_next;
            d3_reg          <= d3_next;
            d4_reg          <= d4_next;
            seen_reg        <= seen_next;
            in_region_reg   <= in_region_next;
            start_depth_reg <= start_depth_next;
            stop_depth_reg  <= stop_depth_next;
            err_reg         <= err_next;
            ovf_reg         <= ovf_next;
            last_reg        <= last_next;
            step_reg        <= step_next;
            tst_reg         <= tst_next;
            k_reg           <= k_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        beat_reg       <= beat_next;
        lhs_reg        <= lhs_next;
        prod_reg       <= prod_next;
        res_start_reg  <= res_start_next;
        res_stop_reg   <= res_stop_next;
        res_rvalid_reg <= res_rvalid_next;
        res_count_reg  <= res_count_next;
        res_err_reg    <= res_err_next;
        res_ovf_reg    <= res_ovf_next;
        res_last_reg   <= res_last_next;
    end

    // Write and read the region stacks
    always_ff @(posedge clk)
    begin
        if (start_we)
            start_mem[start_waddr] <= start_wdata;
        if (stop_we)
            stop_mem[stop_waddr] <= stop_wdata;
        rd_start_reg <= start_mem[start_raddr];
        rd_stop_reg  <= stop_mem[stop_raddr];
    end

endmodule
